### sv/lorenz_euler_integrator_assert.svh
// assertion macros for the lorenz euler integrator
// included by the top level; depends on nothing
`ifndef LORENZ_EULER_INTEGRATOR_ASSERT_SVH
`define LORENZ_EULER_INTEGRATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LEI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lei assertion failed");

// next-cycle implication, checked outside reset
`define LEI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lei assertion failed");

`endif

### sv/lei_pkg.sv
// shared types and constants of the lorenz euler integrator
// no dependencies
package lei_pkg;

	// product sequence, one code per multiplication of a step
	typedef logic [3:0] op_t;
	localparam op_t OP_DX = 4'd0;	// sigma * (y - x)
	localparam op_t OP_RZ = 4'd1;	// x * (rho - z)
	localparam op_t OP_XY = 4'd2;	// x * y
	localparam op_t OP_BZ = 4'd3;	// beta * z
	localparam op_t OP_NX = 4'd4;	// dt * dx
	localparam op_t OP_NY = 4'd5;	// dt * dy
	localparam op_t OP_NZ = 4'd6;	// dt * dz
	localparam op_t OP_OX = 4'd7;	// new x * scale
	localparam op_t OP_OY = 4'd8;	// new y * scale
	localparam op_t OP_OZ = 4'd9;	// new z * scale
	localparam op_t OP_LAST = OP_OZ;

	// register indexes
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_SIGMA = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BETA  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RHO   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DT    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SCALE = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_COUNT = 3'd5;

	localparam int STEP_COUNT_W = 21;
	localparam logic [STEP_COUNT_W-1:0] STEP_COUNT_RST = 21'd50000;

	// reset coefficients as ratios of integers, rounded to nearest
	localparam int SIGMA_RST_INT = 10;
	localparam int RHO_RST_INT   = 28;
	localparam int BETA_RST_NUM  = 26666;
	localparam int BETA_RST_DEN  = 10000;
	localparam int DT_RST_DEN    = 1000;
	localparam int SCALE_RST_NUM = 4;
	localparam int SCALE_RST_DEN = 100;

	// multiplier splits magnitudes into halves of this width
	localparam int MUL_HALF = 32;

	typedef struct packed {
		logic load;		// transaction accepted, apply restart
		logic mul_start;	// launch product for op
		op_t  op;
		logic wb;		// product ready, store for wb_op
		op_t  wb_op;
		logic commit;		// move result to output register, update state
	} lei_cmd_t;

	typedef struct packed {
		logic mul_busy;
		logic mul_done;
		logic out_free;
	} lei_status_t;

endpackage

### sv/lei_in_if.sv
// input channel of the lorenz euler integrator: one restart flag per transaction
// no dependencies
interface lei_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

### sv/lei_out_if.sv
// output channel of the lorenz euler integrator: one scaled point per transaction
// no dependencies
interface lei_out_if #(
	parameter int WORD_WIDTH = 48
);
	logic                  valid;
	logic                  ready;
	logic [WORD_WIDTH-1:0] x_out;
	logic [WORD_WIDTH-1:0] y_out;
	logic [WORD_WIDTH-1:0] z_out;
	logic                  last_step;

	modport source (output valid, output x_out, output y_out, output z_out,
		output last_step, input ready);
	modport sink (input valid, input x_out, input y_out, input z_out,
		input last_step, output ready);
endinterface

### sv/lei_mul.sv
// sequential fixed-point multiplier: four 32x32 partial products, floor shift, saturation
// depends on lei_pkg
module lei_mul #(
	parameter int WORD_WIDTH = 48,
	parameter int FRAC_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [WORD_WIDTH-1:0] a,
	input  logic signed [WORD_WIDTH-1:0] b,
	output logic                         busy,
	output logic                         done,
	output logic        [WORD_WIDTH-1:0] result
);
	import lei_pkg::*;

	localparam int MAG_W = 2 * MUL_HALF;
	localparam int PROD_W = 2 * MAG_W;
	localparam int Q_W = PROD_W - FRAC_BITS;
	localparam int PH_W = 3;
	localparam logic [PH_W-1:0] PH_LAST_PP = 3'd3;
	localparam logic [PH_W-1:0] PH_RND = 3'd5;
	localparam logic [PH_W-1:0] PH_SAT = 3'd6;
	localparam logic [WORD_WIDTH-1:0] WMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
	localparam logic [WORD_WIDTH-1:0] WMIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

	logic signed [MAG_W-1:0] a_ext, b_ext;
	logic [MAG_W-1:0] a_mag, b_mag;
	logic [MAG_W-1:0] a_q, b_q;
	logic neg_q;
	logic busy_q, done_q;
	logic [PH_W-1:0] ph_q;
	logic [MUL_HALF-1:0] a_half, b_half;
	logic [MAG_W-1:0] pp_d, pp_s1;
	logic [1:0] pp_sh_s1;
	logic pp_vld_s1;
	logic [PROD_W-1:0] pp_shifted;
	logic [PROD_W-1:0] acc_q;
	logic [Q_W-1:0] q_q;
	logic [Q_W-1:0] lim;
	logic [WORD_WIDTH-1:0] res_q;

	assign a_ext = MAG_W'(a);
	assign b_ext = MAG_W'(b);
	assign a_mag = a_ext[MAG_W-1] ? (MAG_W'(0) - a_ext) : a_ext;
	assign b_mag = b_ext[MAG_W-1] ? (MAG_W'(0) - b_ext) : b_ext;

	// phase bit 1 picks the half of a, bit 0 the half of b
	assign a_half = ph_q[1] ? a_q[MAG_W-1:MUL_HALF] : a_q[MUL_HALF-1:0];
	assign b_half = ph_q[0] ? b_q[MAG_W-1:MUL_HALF] : b_q[MUL_HALF-1:0];
	assign pp_d = a_half * b_half;

	always_comb begin
		case (pp_sh_s1)
			2'd0: pp_shifted = PROD_W'(pp_s1);
			2'd1: pp_shifted = PROD_W'(pp_s1) << MUL_HALF;
			default: pp_shifted = PROD_W'(pp_s1) << (2 * MUL_HALF);
		endcase
	end

	assign lim = Q_W'(WMAX) + Q_W'(neg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q <= '0;
			pp_vld_s1 <= 1'b0;
		end else begin
			done_q <= 1'b0;
			pp_vld_s1 <= busy_q && (ph_q <= PH_LAST_PP);
			if (start) begin
				busy_q <= 1'b1;
				ph_q <= '0;
			end else if (busy_q) begin
				ph_q <= ph_q + PH_W'(1);
				if (ph_q == PH_SAT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pp_s1 <= pp_d;
		pp_sh_s1 <= {1'b0, ph_q[1]} + {1'b0, ph_q[0]};
		if (start) begin
			a_q <= a_mag;
			b_q <= b_mag;
			neg_q <= a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1];
			acc_q <= '0;
		end else if (pp_vld_s1) begin
			acc_q <= acc_q + pp_shifted;
		end
		// floor of a negative product rounds the magnitude up
		if (busy_q && ph_q == PH_RND)
			q_q <= acc_q[PROD_W-1:FRAC_BITS] + Q_W'(neg_q && (|acc_q[FRAC_BITS-1:0]));
		if (busy_q && ph_q == PH_SAT) begin
			if (q_q > lim)
				res_q <= neg_q ? WMIN : WMAX;
			else
				res_q <= neg_q ? WORD_WIDTH'(Q_W'(0) - q_q) : q_q[WORD_WIDTH-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign result = res_q;

endmodule

### sv/lei_datapath.sv
// datapath of the lorenz euler integrator: registers, state, operand select, output register
// depends on lei_pkg and lei_mul
module lei_datapath #(
	parameter int WORD_WIDTH = 48,
	parameter int FRAC_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [lei_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [WORD_WIDTH-1:0]            cfg_data,
	input  lei_pkg::lei_cmd_t                cmd,
	output lei_pkg::lei_status_t             status,
	input  logic                             restart,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [WORD_WIDTH-1:0]            x_out,
	output logic [WORD_WIDTH-1:0]            y_out,
	output logic [WORD_WIDTH-1:0]            z_out,
	output logic                             last_step
);
	import lei_pkg::*;

	localparam logic [WORD_WIDTH-1:0] WMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
	localparam logic [WORD_WIDTH-1:0] WMIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
	localparam logic [127:0] ONE_FULL = 128'd1 << FRAC_BITS;
	localparam logic [WORD_WIDTH-1:0] ONE_POS =
		(FRAC_BITS < WORD_WIDTH - 1) ? WORD_WIDTH'(ONE_FULL) : WMAX;
	localparam logic [WORD_WIDTH-1:0] SIGMA_RST = WORD_WIDTH'(ONE_FULL * SIGMA_RST_INT);
	localparam logic [WORD_WIDTH-1:0] RHO_RST = WORD_WIDTH'(ONE_FULL * RHO_RST_INT);
	localparam logic [WORD_WIDTH-1:0] BETA_RST =
		WORD_WIDTH'((ONE_FULL * BETA_RST_NUM + BETA_RST_DEN / 2) / BETA_RST_DEN);
	localparam logic [WORD_WIDTH-2:0] DT_RST =
		(WORD_WIDTH-1)'((ONE_FULL + DT_RST_DEN / 2) / DT_RST_DEN);
	localparam logic [WORD_WIDTH-1:0] SCALE_RST =
		WORD_WIDTH'((ONE_FULL * SCALE_RST_NUM + SCALE_RST_DEN / 2) / SCALE_RST_DEN);

	function automatic logic [WORD_WIDTH-1:0] sat_sum(
		input logic [WORD_WIDTH-1:0] a,
		input logic [WORD_WIDTH-1:0] b,
		input logic sub
	);
		logic [WORD_WIDTH:0] ae, be, s;
		ae = {a[WORD_WIDTH-1], a};
		be = {b[WORD_WIDTH-1], b};
		s = sub ? (ae - be) : (ae + be);
		if (s[WORD_WIDTH] != s[WORD_WIDTH-1])
			sat_sum = s[WORD_WIDTH] ? WMIN : WMAX;
		else
			sat_sum = s[WORD_WIDTH-1:0];
	endfunction

	// configuration
	logic [WORD_WIDTH-1:0] sigma_q, beta_q, rho_q, scale_q;
	logic [WORD_WIDTH-2:0] dt_q;
	logic [STEP_COUNT_W-1:0] count_q;
	// run state
	logic [WORD_WIDTH-1:0] x_q, y_q, z_q;
	logic [STEP_COUNT_W-1:0] steps_q;
	// step temporaries
	logic [WORD_WIDTH-1:0] dx_q, dy_q, dz_q, nx_q, ny_q, nz_q, ox_q, oy_q, oz_q;
	// output register
	logic out_valid_q;
	logic [WORD_WIDTH-1:0] xo_q, yo_q, zo_q;
	logic last_q;

	logic signed [WORD_WIDTH-1:0] mul_a, mul_b;
	logic [WORD_WIDTH-1:0] prod;
	logic mul_busy, mul_done;
	logic [WORD_WIDTH-1:0] diff_yx, diff_rz;
	logic [STEP_COUNT_W-1:0] limit;
	logic last;

	assign diff_yx = sat_sum(y_q, x_q, 1'b1);
	assign diff_rz = sat_sum(rho_q, z_q, 1'b1);

	always_comb begin
		case (cmd.op)
			OP_DX: begin mul_a = sigma_q; mul_b = diff_yx; end
			OP_RZ: begin mul_a = x_q; mul_b = diff_rz; end
			OP_XY: begin mul_a = x_q; mul_b = y_q; end
			OP_BZ: begin mul_a = beta_q; mul_b = z_q; end
			OP_NX: begin mul_a = {1'b0, dt_q}; mul_b = dx_q; end
			OP_NY: begin mul_a = {1'b0, dt_q}; mul_b = dy_q; end
			OP_NZ: begin mul_a = {1'b0, dt_q}; mul_b = dz_q; end
			OP_OX: begin mul_a = nx_q; mul_b = scale_q; end
			OP_OY: begin mul_a = ny_q; mul_b = scale_q; end
			OP_OZ: begin mul_a = nz_q; mul_b = scale_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	lei_mul #(
		.WORD_WIDTH(WORD_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.mul_start),
		.a(mul_a),
		.b(mul_b),
		.busy(mul_busy),
		.done(mul_done),
		.result(prod)
	);

	// zero step count acts as one
	assign limit = (count_q == '0) ? STEP_COUNT_W'(1) : count_q;
	assign last = ({1'b0, steps_q} + (STEP_COUNT_W+1)'(1)) >= {1'b0, limit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= SIGMA_RST;
			beta_q <= BETA_RST;
			rho_q <= RHO_RST;
			dt_q <= DT_RST;
			scale_q <= SCALE_RST;
			count_q <= STEP_COUNT_RST;
			x_q <= ONE_POS;
			y_q <= ONE_POS;
			z_q <= ONE_POS;
			steps_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_SIGMA: sigma_q <= cfg_data;
					REG_BETA:  beta_q <= cfg_data;
					REG_RHO:   rho_q <= cfg_data;
					REG_DT:    dt_q <= cfg_data[WORD_WIDTH-2:0];
					REG_SCALE: scale_q <= cfg_data;
					REG_COUNT: count_q <= cfg_data[STEP_COUNT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load && restart) begin
				x_q <= ONE_POS;
				y_q <= ONE_POS;
				z_q <= ONE_POS;
				steps_q <= '0;
			end else if (cmd.commit) begin
				x_q <= last ? ONE_POS : nx_q;
				y_q <= last ? ONE_POS : ny_q;
				z_q <= last ? ONE_POS : nz_q;
				steps_q <= last ? '0 : steps_q + STEP_COUNT_W'(1);
			end
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			case (cmd.wb_op)
				OP_DX: dx_q <= prod;
				OP_RZ: dy_q <= sat_sum(prod, y_q, 1'b1);
				OP_XY: dz_q <= prod;
				OP_BZ: dz_q <= sat_sum(dz_q, prod, 1'b1);
				OP_NX: nx_q <= sat_sum(x_q, prod, 1'b0);
				OP_NY: ny_q <= sat_sum(y_q, prod, 1'b0);
				OP_NZ: nz_q <= sat_sum(z_q, prod, 1'b0);
				OP_OX: ox_q <= prod;
				OP_OY: oy_q <= prod;
				OP_OZ: oz_q <= prod;
				default: ;
			endcase
		end
		if (cmd.commit) begin
			xo_q <= ox_q;
			yo_q <= oy_q;
			zo_q <= oz_q;
			last_q <= last;
		end
	end

	assign status.mul_busy = mul_busy;
	assign status.mul_done = mul_done;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign x_out = xo_q;
	assign y_out = yo_q;
	assign z_out = zo_q;
	assign last_step = last_q;

endmodule

### sv/lei_ctrl.sv
// controller of the lorenz euler integrator: sequences the ten products of a step
// depends on lei_pkg
module lei_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output lei_pkg::lei_cmd_t    cmd,
	input  lei_pkg::lei_status_t status
);
	import lei_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q, state_d;
	op_t op_q, op_d;

	always_comb begin
		state_d = state_q;
		op_d = op_q;
		in_ready = 1'b0;
		cmd = '0;
		cmd.op = op_q;
		cmd.wb_op = op_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					op_d = OP_DX;
					state_d = ST_START;
				end
			end
			ST_START: begin
				cmd.mul_start = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (status.mul_done) begin
					cmd.wb = 1'b1;
					if (op_q == OP_LAST) begin
						state_d = ST_DONE;
					end else begin
						// next product launches as this one is stored
						op_d = op_q + op_t'(1);
						cmd.op = op_d;
						cmd.mul_start = 1'b1;
					end
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_DX;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
		end
	end

endmodule

### sv/lorenz_euler_integrator.sv
// top level of the lorenz euler integrator: controller, datapath and checks
// depends on lei_pkg, lei_in_if, lei_out_if, lei_ctrl, lei_datapath and the assert header
//
// usage
// - step channel: each transaction advances (x, y, z) by one explicit euler step;
//   restart set reloads the start point (1,1,1) and clears the step count first
// - point channel: one transaction per step with the new point times output_scale
//   and last_step marking the final step of a run, after which the start point returns
// - config port: cfg_wr_en, cfg_index, cfg_data; write only while the block is idle
// - one step in flight: the next step is accepted only once the current step has
//   committed its point
// - the cost is set by ten dependent products on one shared multiplier, each made of
//   four 32x32 partial products, accumulate, floor and saturate
// - the point sits in an output register: a new step is accepted while it waits, and
//   only the commit of the following step holds off until the receiver takes it
// - reset (arst_n low) loads the default coefficients, the start point and a zero step count
`include "lorenz_euler_integrator_assert.svh"

module lorenz_euler_integrator #(
	parameter int WORD_WIDTH = 48,
	parameter int FRAC_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [lei_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [WORD_WIDTH-1:0]           cfg_data,
	lei_in_if.sink                          step,
	lei_out_if.source                       point
);
	import lei_pkg::*;

	lei_cmd_t cmd;
	lei_status_t status;

	// sequencer: accepts steps, walks the product list, commits results
	lei_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(step.valid),
		.in_ready(step.ready),
		.cmd(cmd),
		.status(status)
	);

	// registers, state, shared multiplier and output register
	lei_datapath #(
		.WORD_WIDTH(WORD_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.status(status),
		.restart(step.restart),
		.out_ready(point.ready),
		.out_valid(point.valid),
		.x_out(point.x_out),
		.y_out(point.y_out),
		.z_out(point.z_out),
		.last_step(point.last_step)
	);

	// one step at a time: after acceptance the input side is closed
	`LEI_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, step.valid && step.ready, !step.ready)
	// a result never overwrites a point the receiver has not taken
	`LEI_ASSERT_IMPL(a_commit_free, clk, arst_n, cmd.commit, !point.valid || point.ready)
	// the shared multiplier is never relaunched mid-product
	`LEI_ASSERT_IMPL(a_start_idle, clk, arst_n, cmd.mul_start, !status.mul_busy)

endmodule
